// ===== hw/rtl/fpfr_pkg.sv =====
// Package for the FIFO page frame replacement unit.
// Holds the field widths, the stream packing layout and the default sizes.
// No dependencies.
package fpfr_pkg;

    // Default sizes of the frame table.
    localparam int FRAMES_DEFAULT = 64;
    localparam int PAGES          = 1024;

    // Field widths.
    localparam int CFG_W       = 7;
    localparam int PAGE_W      = 10;
    localparam int FRAME_FLD_W = 6;
    localparam int COUNT_W     = 32;

    // Reset value of the frames_in_use register.
    localparam logic [CFG_W-1:0] FRAMES_IN_USE_RESET = 7'd64;

    // Stream payload widths, padded to whole bytes.
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 80;

    typedef logic [PAGE_W-1:0]  page_t;
    typedef logic [COUNT_W-1:0] count_t;

endpackage

// ===== hw/rtl/fifo_page_frame_replacement_unit.sv =====
// FIFO page frame replacement unit: top level.
// Frame table in a synchronous single-port memory, fill count, FIFO pointer, counters.
// Depends on fpfr_pkg.

// Each accepted fault on the s_ channel yields one result transaction on the m_ channel.
// A fault runs through the accept cycle, in which the frame table memory is read at the
// chosen frame and written with the new page, and the read state, in which the registered
// read data reaches the output register. A new fault is taken in the same cycle as the
// previous result leaves. Frames are filled from frame 0 upward, so a fill count stands in
// for the used marks and no clearing pass is needed after reset. The user is to write the
// frames_in_use register through cfg_we and cfg_wdata only while the unit is idle; the
// block does not enforce this. 0 acts as 1 and values above FRAMES act as FRAMES.
module fifo_page_frame_replacement_unit #(
    parameter int FRAMES = fpfr_pkg::FRAMES_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration: frames_in_use
    input  logic                            cfg_we,
    input  logic [fpfr_pkg::CFG_W-1:0]      cfg_wdata,
    // Fault input. tdata: fault_page [9:0], zero pad [15:10]
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fpfr_pkg::S_TDATA_W-1:0]  s_tdata,
    // Result output. tdata: load_frame [5:0], evicted_page [15:6],
    // fault_count [47:16], writeback_count [79:48]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fpfr_pkg::M_TDATA_W-1:0]  m_tdata,
    // tuser: write_back [0]
    output logic                            m_tuser
);
    import fpfr_pkg::*;

    localparam int F_W    = $clog2(FRAMES);
    localparam int N_W    = $clog2(FRAMES + 1);
    localparam int CMP_W  = (N_W > CFG_W) ? N_W : CFG_W;
    localparam int SLOT_W = (F_W > FRAME_FLD_W) ? F_W : FRAME_FLD_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic              state_reg;
    logic [CFG_W-1:0]  frames_in_use_reg;
    logic [N_W-1:0]    fill_reg, fill_next;
    logic [F_W-1:0]    oldest_reg, oldest_next;
    count_t            faults_reg, faults_next;
    count_t            wbs_reg, wbs_next;

    logic [F_W-1:0]    slot_reg;
    logic              wb_reg;

    logic              out_valid_reg;
    logic [FRAME_FLD_W-1:0] out_frame_reg;
    logic              out_wb_reg;
    page_t             out_evicted_reg;
    count_t            out_faults_reg;
    count_t            out_wbs_reg;

    logic [CMP_W-1:0]  cfg_ext;
    logic [N_W-1:0]    n_eff;
    logic              accept;
    logic              has_free;
    logic [F_W-1:0]    victim;
    logic [F_W-1:0]    slot;
    logic [CMP_W-1:0]  victim_inc;
    logic [SLOT_W-1:0] slot_wide;

    page_t             frame_owner_mem [FRAMES];
    page_t             rd_data_reg;

    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    // Clamp the active frame count to 1..FRAMES.
    always_comb begin
        cfg_ext = CMP_W'(frames_in_use_reg);
        if (cfg_ext == '0) begin
            n_eff = N_W'(1);
        end else if (cfg_ext > CMP_W'(FRAMES)) begin
            n_eff = N_W'(FRAMES);
        end else begin
            n_eff = N_W'(cfg_ext);
        end
    end

    // Frame choice: next unfilled frame, else the FIFO victim.
    always_comb begin
        has_free    = fill_reg < n_eff;
        victim      = (N_W'(oldest_reg) < n_eff) ? oldest_reg : '0;
        victim_inc  = CMP_W'(victim) + CMP_W'(1);
        slot        = has_free ? fill_reg[F_W-1:0] : victim;
        fill_next   = fill_reg;
        oldest_next = oldest_reg;
        wbs_next    = wbs_reg;
        faults_next = faults_reg + COUNT_W'(1);
        if (has_free) begin
            fill_next = fill_reg + N_W'(1);
        end else begin
            wbs_next    = wbs_reg + COUNT_W'(1);
            oldest_next = (victim_inc < CMP_W'(n_eff)) ? victim_inc[F_W-1:0] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            frames_in_use_reg <= FRAMES_IN_USE_RESET;
            fill_reg          <= '0;
            oldest_reg        <= '0;
            faults_reg        <= '0;
            wbs_reg           <= '0;
            out_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                frames_in_use_reg <= cfg_wdata;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg  <= ST_READ;
                        fill_reg   <= fill_next;
                        oldest_reg <= oldest_next;
                        faults_reg <= faults_next;
                        wbs_reg    <= wbs_next;
                    end
                end
                ST_READ: begin
                    state_reg <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (state_reg == ST_READ) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Read-first single port: the old owner comes out while the new page goes in.
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_data_reg             <= frame_owner_mem[slot];
            frame_owner_mem[slot]   <= s_tdata[PAGE_W-1:0];
        end
    end

    assign slot_wide = SLOT_W'(slot_reg);

    always_ff @(posedge aclk) begin
        if (accept) begin
            slot_reg <= slot;
            wb_reg   <= !has_free;
        end
        if (state_reg == ST_READ) begin
            out_frame_reg   <= slot_wide[FRAME_FLD_W-1:0];
            out_wb_reg      <= wb_reg;
            out_evicted_reg <= wb_reg ? rd_data_reg : '0;
            out_faults_reg  <= faults_reg;
            out_wbs_reg     <= wbs_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_wb_reg;
    assign m_tdata  = {out_wbs_reg, out_faults_reg, out_evicted_reg, out_frame_reg};

    // A result appears only after the memory read cycle.
    a_out_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_READ))
        else $error("result raised without a frame table read");

    // An accepted fault is always followed by the read cycle.
    a_read_follows_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_READ))
        else $error("accepted fault did not enter the read cycle");

    // Without an eviction the evicted page field is zero.
    a_no_wb_zero_page: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[15:6] == '0))
        else $error("evicted page nonzero without write-back");

    // The fill count never passes the table depth.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (CMP_W'(fill_reg) <= CMP_W'(FRAMES)))
        else $error("fill count beyond frame table depth");

endmodule
